FILE: design/ucd_pkg.sv
package ucd_pkg;

  // Field widths of the request and the result.
  localparam int TS_W     = 39;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Accepted span: 0000-01-01 00:00:00 through 9999-12-31 23:59:59.
  localparam logic signed [TS_W-1:0] TS_MIN = -39'sd62167219200;
  localparam logic signed [TS_W-1:0] TS_MAX = 39'sd253402300799;
  // Seconds from 0000-01-01 to 1970-01-01.
  localparam logic [TS_W-1:0] EPOCH_OFS = 39'd62167219200;

  // 86400 = 2^7 * 675; the power of two is split off as a shift.
  localparam int SEC_SHIFT     = 7;
  localparam int DAY_DIV_ODD   = 675;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  localparam int DAYS_PER_ERA  = 146097;
  // One era ahead, minus January and February of year 0.
  localparam int MARCH_OFS     = 146037;
  localparam int DAYS_PER_4Y   = 1460;
  localparam int DAYS_PER_100Y = 36524;
  localparam int DAYS_ERA_LAST = 146096;
  localparam int DAYS_PER_YEAR = 365;
  localparam int MONTH_SPAN    = 153;
  localparam int YEARS_PER_ERA = 400;

  // Register stages of the constant divider.
  localparam int DIV_STAGES = 3;

  // Months counted from March: index 10 and 11 are January and February.
  localparam logic [3:0] MP_JAN = 4'd10;

  // First day of a March-based month within the year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Calendar month, 1 is January, from a March-based month index.
  function automatic logic [3:0] month_of(input logic [3:0] mp);
    logic [3:0] m;
    if (mp < MP_JAN) begin
      m = mp + 4'd3;
    end else begin
      m = mp - 4'd9;
    end
    return m;
  endfunction

endpackage

FILE: design/ucd_cdiv.sv
module ucd_cdiv #(
  parameter int unsigned XW  = 32,
  parameter int unsigned QW  = 22,
  parameter int unsigned DIV = 675,
  parameter int unsigned SW  = 1,
  parameter int unsigned RW  = $clog2(DIV)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o,
  output logic [SW-1:0] side_o
);
  import ucd_pkg::*;

  // Reciprocal rounded down, scaled so that 2^XW covers every x. The estimate
  // is then the true quotient or one below it, and the last stage corrects it.
  localparam int unsigned MW = XW - $clog2(DIV) + 1;
  localparam logic [63:0] M_L = (64'd1 << XW) / DIV;
  localparam logic [MW-1:0] M = M_L[MW-1:0];
  localparam int unsigned PW = XW + MW;

  logic [DIV_STAGES-1:0] vld_r, vld_nxt;

  logic [XW-1:0] x1_r, x2_r;
  logic [PW-1:0] prod1_r, prod1_nxt;
  logic [SW-1:0] side1_r, side2_r, side3_r;
  logic [QW-1:0] q2_r, q2_nxt, q3_r, q3_nxt;
  logic [XW-1:0] t2_r, t2_nxt;
  logic [XW-1:0] diff;
  logic          fix;
  logic [RW-1:0] r3_r, r3_nxt;

  assign vld_nxt = {vld_r[DIV_STAGES-2:0], vld_i};

  assign prod1_nxt = PW'(x_i) * PW'(M);
  assign q2_nxt    = prod1_r[XW +: QW];
  assign t2_nxt    = XW'(q2_nxt) * XW'(DIV);
  assign diff      = x2_r - t2_r;
  assign fix       = (diff >= XW'(DIV));
  assign q3_nxt    = fix ? (q2_r + QW'(1)) : q2_r;
  assign r3_nxt    = fix ? RW'(diff - XW'(DIV)) : RW'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x_i;
    prod1_r <= prod1_nxt;
    side1_r <= side_i;
    x2_r    <= x1_r;
    q2_r    <= q2_nxt;
    t2_r    <= t2_nxt;
    side2_r <= side1_r;
    q3_r    <= q3_nxt;
    r3_r    <= r3_nxt;
    side3_r <= side2_r;
  end

  assign vld_o  = vld_r[DIV_STAGES-1];
  assign q_o    = q3_r;
  assign r_o    = r3_r;
  assign side_o = side3_r;

endmodule

FILE: design/unix_time_to_civil_date_core.sv
// Throughput: one request per clock; busy is low whenever reset is not held.
// The fixed-depth pipeline holds five reciprocal-multiply dividers in a chain
// (three stages each) and six stages of add and compare logic.
// Results leave on a one-cycle strobe; the receiver cannot stall the pipe.
// Synchronous active-low reset clears every valid bit; data registers are not reset.
module unix_time_to_civil_date_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ucd_pkg::TS_W-1:0]     in_unix_seconds,
  output logic                                out_valid,
  output logic [ucd_pkg::YEAR_W-1:0]          out_year,
  output logic [ucd_pkg::MONTH_W-1:0]         out_month,
  output logic [ucd_pkg::DAY_W-1:0]           out_day,
  output logic [ucd_pkg::HOUR_W-1:0]          out_hour,
  output logic [ucd_pkg::MINUTE_W-1:0]        out_minute,
  output logic [ucd_pkg::SECOND_W-1:0]        out_second
);
  import ucd_pkg::*;

  localparam int LATENCY = 5 * DIV_STAGES + 6;

  logic accept;

  // Clamp and shift to seconds since year 0.
  logic                   v1_r, v2_r;
  logic signed [TS_W-1:0] t1_r, t1_nxt;
  logic [TS_W-1:0]        s2_r, s2_nxt;

  // Days and seconds of day.
  logic        vd1;
  logic [21:0] days1;
  logic [9:0]  r1;
  logic [6:0]  slo1;
  logic        v3_r;
  logic [21:0] d3_r, d3_nxt;
  logic [16:0] secs3_r, secs3_nxt;

  // Era and day of era.
  logic        vd2;
  logic [4:0]  era2;
  logic [17:0] doe2;
  logic [16:0] secs2;
  logic [2:0]  b2;
  logic        c2;

  logic        vd4;
  logic [6:0]  a4;
  logic [17:0] doe4;
  logic [2:0]  b4;
  logic        c4;
  logic [4:0]  hour4;
  logic [11:0] remh4;
  logic [4:0]  era4;

  logic        v5_r;
  logic [17:0] n5_r, n5_nxt;
  logic [6:0]  adj5_r, adj5_nxt;
  logic [11:0] remh5_r;
  logic [4:0]  hour5_r;
  logic [4:0]  era5_r;

  // Year of era and day of year.
  logic        vd6;
  logic [8:0]  yoe6;
  logic [8:0]  rem6;
  logic [6:0]  adj6;
  logic [4:0]  era6;
  logic [5:0]  min6;
  logic [5:0]  sec6;
  logic [4:0]  hour6;
  logic [1:0]  cent6;
  logic [10:0] doy_sum;

  logic                v7_r;
  logic [8:0]          doy7_r, doy7_nxt;
  logic [YEAR_W-1:0]   y7_r, y7_nxt;
  logic [4:0]          hour7_r;
  logic [5:0]          min7_r;
  logic [5:0]          sec7_r;
  logic [10:0]         mx7;

  // Month index.
  logic                vd8;
  logic [3:0]          mp8;
  logic [8:0]          doy8;
  logic [YEAR_W-1:0]   y8;
  logic [4:0]          hour8;
  logic [5:0]          min8;
  logic [5:0]          sec8;
  logic [8:0]          day_sum;

  logic                  out_valid_r;
  logic [YEAR_W-1:0]     year_r, year_nxt;
  logic [MONTH_W-1:0]    month_r, month_nxt;
  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [HOUR_W-1:0]     hour_r;
  logic [MINUTE_W-1:0]   min_r;
  logic [SECOND_W-1:0]   sec_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Out-of-span times saturate to the first or last second of the span.
  always_comb begin
    if (in_unix_seconds < TS_MIN) begin
      t1_nxt = TS_MIN;
    end else if (in_unix_seconds > TS_MAX) begin
      t1_nxt = TS_MAX;
    end else begin
      t1_nxt = in_unix_seconds;
    end
  end

  assign s2_nxt = $unsigned(t1_r) + EPOCH_OFS;

  ucd_cdiv #(
    .XW(TS_W - SEC_SHIFT), .QW(22), .DIV(DAY_DIV_ODD), .SW(SEC_SHIFT)
  ) u_div_day (
    .clk(clk), .rst_n(rst_n), .vld_i(v2_r),
    .x_i(s2_r[TS_W-1:SEC_SHIFT]), .side_i(s2_r[SEC_SHIFT-1:0]),
    .vld_o(vd1), .q_o(days1), .r_o(r1), .side_o(slo1)
  );

  assign d3_nxt    = days1 + 22'(MARCH_OFS);
  assign secs3_nxt = {r1, slo1};

  ucd_cdiv #(
    .XW(22), .QW(5), .DIV(DAYS_PER_ERA), .SW(17)
  ) u_div_era (
    .clk(clk), .rst_n(rst_n), .vld_i(v3_r),
    .x_i(d3_r), .side_i(secs3_r),
    .vld_o(vd2), .q_o(era2), .r_o(doe2), .side_o(secs2)
  );

  // Centuries within the era and the last day of the era, by comparison.
  assign b2 = 3'(doe2 >= 18'(DAYS_PER_100Y)) + 3'(doe2 >= 18'(2 * DAYS_PER_100Y))
            + 3'(doe2 >= 18'(3 * DAYS_PER_100Y)) + 3'(doe2 >= 18'(DAYS_ERA_LAST));
  assign c2 = (doe2 >= 18'(DAYS_ERA_LAST));

  ucd_cdiv #(
    .XW(18), .QW(7), .DIV(DAYS_PER_4Y), .SW(22)
  ) u_div_4y (
    .clk(clk), .rst_n(rst_n), .vld_i(vd2),
    .x_i(doe2), .side_i({doe2, b2, c2}),
    .vld_o(vd4), .q_o(a4), .r_o(), .side_o({doe4, b4, c4})
  );

  ucd_cdiv #(
    .XW(17), .QW(5), .DIV(SECS_PER_HOUR), .SW(5)
  ) u_div_hour (
    .clk(clk), .rst_n(rst_n), .vld_i(vd2),
    .x_i(secs2), .side_i(era2),
    .vld_o(), .q_o(hour4), .r_o(remh4), .side_o(era4)
  );

  // The leap-day correction a - b + c is never negative.
  assign adj5_nxt = a4 - 7'(b4) + 7'(c4);
  assign n5_nxt   = doe4 - 18'(adj5_nxt);

  ucd_cdiv #(
    .XW(18), .QW(9), .DIV(DAYS_PER_YEAR), .SW(12)
  ) u_div_year (
    .clk(clk), .rst_n(rst_n), .vld_i(v5_r),
    .x_i(n5_r), .side_i({adj5_r, era5_r}),
    .vld_o(vd6), .q_o(yoe6), .r_o(rem6), .side_o({adj6, era6})
  );

  ucd_cdiv #(
    .XW(12), .QW(6), .DIV(SECS_PER_MIN), .SW(5)
  ) u_div_min (
    .clk(clk), .rst_n(rst_n), .vld_i(v5_r),
    .x_i(remh5_r), .side_i(hour5_r),
    .vld_o(), .q_o(min6), .r_o(sec6), .side_o(hour6)
  );

  assign cent6 = 2'(yoe6 >= 9'd100) + 2'(yoe6 >= 9'd200) + 2'(yoe6 >= 9'd300);
  // Day of year; intermediate terms may wrap, the final value fits.
  assign doy_sum  = 11'(rem6) + 11'(adj6) - 11'(yoe6[8:2]) + 11'(cent6);
  assign doy7_nxt = doy_sum[8:0];
  assign y7_nxt   = YEAR_W'(yoe6) + YEAR_W'(era6) * YEAR_W'(YEARS_PER_ERA);

  assign mx7 = {doy7_r, 2'b00} + 11'(doy7_r) + 11'd2;

  ucd_cdiv #(
    .XW(11), .QW(4), .DIV(MONTH_SPAN), .SW(40)
  ) u_div_month (
    .clk(clk), .rst_n(rst_n), .vld_i(v7_r),
    .x_i(mx7), .side_i({doy7_r, y7_r, hour7_r, min7_r, sec7_r}),
    .vld_o(vd8), .q_o(mp8), .r_o(), .side_o({doy8, y8, hour8, min8, sec8})
  );

  assign day_sum   = doy8 - month_start(mp8) + 9'd1;
  assign day_nxt   = day_sum[DAY_W-1:0];
  assign month_nxt = month_of(mp8);
  // January and February belong to the next calendar year; eras start one ahead.
  assign year_nxt  = y8 + YEAR_W'(mp8 >= MP_JAN) - YEAR_W'(YEARS_PER_ERA);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v5_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= vd1;
      v5_r        <= vd4;
      v7_r        <= vd6;
      out_valid_r <= vd8;
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= t1_nxt;
    s2_r    <= s2_nxt;
    d3_r    <= d3_nxt;
    secs3_r <= secs3_nxt;
    n5_r    <= n5_nxt;
    adj5_r  <= adj5_nxt;
    remh5_r <= remh4;
    hour5_r <= hour4;
    era5_r  <= era4;
    doy7_r  <= doy7_nxt;
    y7_r    <= y7_nxt;
    hour7_r <= hour6;
    min7_r  <= min6;
    sec7_r  <= sec6;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    hour_r  <= hour8;
    min_r   <= min8;
    sec_r   <= sec8;
  end

  assign out_valid  = out_valid_r;
  assign out_year   = year_r;
  assign out_month  = month_r;
  assign out_day    = day_r;
  assign out_hour   = hour_r;
  assign out_minute = min_r;
  assign out_second = sec_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, LATENCY))
    else $error("result strobe does not match request latency");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day >= 5'd1 && out_year <= 14'd9999))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60))
    else $error("time of day field out of range");

  a_feb_days: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_month == 4'd2) |-> (out_day <= 5'd29))
    else $error("February day beyond 29");

endmodule

FILE: sim/tb_unix_time_to_civil_date_core.sv
module tb_unix_time_to_civil_date_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ucd_pkg::*;

  localparam int  PIPE_LATENCY   = 21;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  RANDOM_ITEMS   = 1000;
  localparam int  MAX_REPORTS    = 10;
  localparam longint SECS_IN_DAY  = 86400;
  localparam longint SECS_IN_HOUR = 3600;
  localparam longint ERA_DAYS     = 146097;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } civil_time_t;

  typedef struct {
    logic signed [TS_W-1:0] ts;
    bit                     drain_first;
  } ts_request_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [TS_W-1:0] in_unix_seconds = '0;
  logic                   out_valid;
  logic [YEAR_W-1:0]      out_year;
  logic [MONTH_W-1:0]     out_month;
  logic [DAY_W-1:0]       out_day;
  logic [HOUR_W-1:0]      out_hour;
  logic [MINUTE_W-1:0]    out_minute;
  logic [SECOND_W-1:0]    out_second;

  ts_request_t pending_ts_q[$];
  civil_time_t expected_dates_q[$];

  ts_request_t next_req;
  int          gap_left = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;
  int          dates_checked = 0;
  int          requests_sent = 0;
  int          saturating_count = 0;
  int          drain_pauses = 0;

  unix_time_to_civil_date_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_unix_seconds (in_unix_seconds),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Days are counted from March 1 of year -400 so that every quantity stays
  // non-negative; January and February then belong to the following year.
  function automatic civil_time_t civil_from_timestamp(input logic signed [TS_W-1:0] ts);
    civil_time_t r;
    longint      t, s, day_num, sod, shifted, era, doe, yoe, doy, mar_month, mday, mon, yr;
    longint      hh, mm, ss;
    t = ts;
    if (ts < TS_MIN) t = longint'(TS_MIN);
    if (ts > TS_MAX) t = longint'(TS_MAX);
    s = t - longint'(TS_MIN);
    day_num = s / SECS_IN_DAY;
    sod = s % SECS_IN_DAY;
    shifted = day_num - 60 + ERA_DAYS;
    era = shifted / ERA_DAYS;
    doe = shifted - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mar_month = (5 * doy + 2) / 153;
    mday = doy - (153 * mar_month + 2) / 5 + 1;
    mon = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
    yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0) - 400;
    hh = sod / SECS_IN_HOUR;
    mm = (sod % SECS_IN_HOUR) / 60;
    ss = sod % 60;
    r.year   = yr[YEAR_W-1:0];
    r.month  = mon[MONTH_W-1:0];
    r.day    = mday[DAY_W-1:0];
    r.hour   = hh[HOUR_W-1:0];
    r.minute = mm[MINUTE_W-1:0];
    r.second = ss[SECOND_W-1:0];
    return r;
  endfunction

  // Mostly back-to-back or short gaps, occasional long ones, and now and then
  // a stretch of requests with no gap at all.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_ts(input logic signed [TS_W-1:0] ts, input bit drain_first);
    ts_request_t req;
    req.ts = ts;
    req.drain_first = drain_first;
    if (ts < TS_MIN || ts > TS_MAX) saturating_count++;
    pending_ts_q.push_back(req);
  endfunction

  // Driver: a request is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_dates_q.push_back(civil_from_timestamp(in_unix_seconds));
        requests_sent++;
        gap_left = pick_gap();
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (start && busy) begin
        // Hold the current request until it is taken.
      end else if (gap_left == 0 && pending_ts_q.size() > 0 &&
                   !(pending_ts_q[0].drain_first && expected_dates_q.size() != 0)) begin
        next_req = pending_ts_q.pop_front();
        if (next_req.drain_first) drain_pauses++;
        start <= 1'b1;
        in_unix_seconds <= next_req.ts;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding date.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_dates_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                   out_year, out_month, out_day, out_hour, out_minute, out_second);
      end else begin
        civil_time_t exp_date;
        exp_date = expected_dates_q.pop_front();
        dates_checked++;
        if (out_year !== exp_date.year || out_month !== exp_date.month ||
            out_day !== exp_date.day || out_hour !== exp_date.hour ||
            out_minute !== exp_date.minute || out_second !== exp_date.second) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                     $realtime, exp_date.year, exp_date.month, exp_date.day,
                     exp_date.hour, exp_date.minute, exp_date.second,
                     out_year, out_month, out_day, out_hour, out_minute, out_second);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d requests queued and %0d dates outstanding",
                 pending_ts_q.size(), expected_dates_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0]            raw;
    longint unsigned        span;
    longint                 day_idx;
    logic signed [TS_W-1:0] ts;
    int                     kind;

    span = longint'(TS_MAX) - longint'(TS_MIN);

    // Span limits, saturation on both sides, day edges around the epoch and
    // century leap rules.
    queue_ts(TS_MIN, 1'b0);
    queue_ts(TS_MAX, 1'b0);
    queue_ts(TS_MIN - TS_W'(1), 1'b0);
    queue_ts(TS_MAX + TS_W'(1), 1'b0);
    queue_ts({1'b1, {(TS_W-1){1'b0}}}, 1'b0);
    queue_ts({1'b0, {(TS_W-1){1'b1}}}, 1'b0);
    queue_ts('0, 1'b0);
    queue_ts(TS_W'(-1), 1'b0);
    queue_ts(TS_W'(1), 1'b0);
    queue_ts(TS_W'(86399), 1'b0);
    queue_ts(TS_W'(86400), 1'b0);
    queue_ts(TS_W'(-86400), 1'b0);
    queue_ts(TS_W'(-86401), 1'b0);
    queue_ts(39'sd951782400, 1'b0);     // leap day of a year divisible by 400
    queue_ts(39'sd951868799, 1'b0);
    queue_ts(39'sd951868800, 1'b0);
    queue_ts(-39'sd2203891201, 1'b0);   // end of February in a century year
    queue_ts(-39'sd2203891200, 1'b0);
    queue_ts(39'sd946684799, 1'b0);
    queue_ts(TS_MIN + TS_W'(59 * 86400), 1'b0);
    queue_ts(TS_MIN + TS_W'(60 * 86400 - 1), 1'b0);
    queue_ts(TS_MAX - TS_W'(86399), 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      raw = {$urandom, $urandom};
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        ts = TS_W'(TS_MIN + (raw % (span + 1)));
      end else if (kind < 75) begin
        ts = raw[TS_W-1:0];
      end else if (kind < 85) begin
        if (raw[63]) ts = TS_MIN + TS_W'($signed($urandom_range(0, 200)) - 100);
        else         ts = TS_MAX + TS_W'($signed($urandom_range(0, 200)) - 100);
      end else begin
        // Just around a midnight, so month and year rollovers come up often.
        day_idx = raw % (span / SECS_IN_DAY + 1);
        ts = TS_W'(TS_MIN + day_idx * SECS_IN_DAY + $signed($urandom_range(0, 4)) - 2);
      end
      queue_ts(ts, (i == 0) || ($urandom_range(0, 99) == 0));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ts_q.size() != 0 || start) @(posedge clk);
    while (expected_dates_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (expected_dates_q.size() != 0) fail_count++;

    $display("Converted %0d timestamps (%0d outside the year 0 to 9999 span), %0d dates checked,",
             requests_sent, saturating_count, dates_checked);
    $display("%0d pauses for a drained pipeline, %0d failures.", drain_pauses, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ucd_pkg.sv
design/ucd_cdiv.sv
design/unix_time_to_civil_date_core.sv
sim/tb_unix_time_to_civil_date_core.sv
